### rtl/wtc_pkg.sv
// Package for the word token classifier.
// Holds token kinds, character codes, sizes and the word classification function.
// No dependencies.
package wtc_pkg;

    localparam int POS_W        = 16;
    localparam int LEN_W        = 8;
    localparam int MAX_WORD_LEN = 255;
    localparam int START_W      = 16;
    localparam int BYTE_W       = 8;
    localparam int FIFO_DEPTH   = 8;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
    localparam int TDATA_W      = 40;

    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [BYTE_W-1:0] CH_EQ     = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;

    typedef enum logic [2:0] {
        KIND_DATATYPE     = 3'd0,
        KIND_OPERATOR     = 3'd1,
        KIND_PUNCTUATOR   = 3'd2,
        KIND_NUMBER       = 3'd3,
        KIND_STRING       = 3'd4,
        KIND_ENDSTATEMENT = 3'd5,
        KIND_ASSIGNMENT   = 3'd6,
        KIND_ERROR        = 3'd7
    } t_kind;

    typedef struct packed {
        logic                last;
        logic [BYTE_W-1:0]   symbol;
        logic [LEN_W-1:0]    length;
        logic [START_W-1:0]  start;
        t_kind               kind;
    } t_token;

    typedef struct packed {
        logic [2:0]          valid;
        t_token [2:0]        tok;
    } t_push;

    function automatic logic is_digit(input logic [BYTE_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [BYTE_W-1:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    // sel 0: "int", sel 1: "str"
    function automatic logic [BYTE_W-1:0] kw_char(input logic sel, input logic [1:0] idx);
        logic [BYTE_W-1:0] ch;
        unique case (idx)
            2'd0:    ch = sel ? 8'h73 : 8'h69;
            2'd1:    ch = sel ? 8'h74 : 8'h6E;
            2'd2:    ch = sel ? 8'h72 : 8'h74;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic t_kind classify(
        input logic [LEN_W-1:0]  len,
        input logic              digits,
        input logic              letters,
        input logic [1:0]        alive,
        input logic [BYTE_W-1:0] c
    );
        t_kind k;
        priority if (len == LEN_W'(3) && alive != 2'b00) k = KIND_DATATYPE;
        else if (digits)                                  k = KIND_NUMBER;
        else if (len == LEN_W'(1) && c == CH_EQ)          k = KIND_ASSIGNMENT;
        else if (len == LEN_W'(1) && (c == CH_STAR || c == CH_PLUS ||
                                      c == CH_MINUS || c == CH_SLASH))
                                                          k = KIND_OPERATOR;
        else if (letters)                                 k = KIND_STRING;
        else                                              k = KIND_ERROR;
        return k;
    endfunction

endpackage

### rtl/wtc_lexer.sv
// Word state and classification for one text byte per cycle.
// Produces up to three tokens per byte. Depends on wtc_pkg.
module wtc_lexer
    import wtc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_last,
    output t_push             o_push
);

    logic [LEN_W-1:0]  r_len,     n_len;
    logic              r_digits,  n_digits;
    logic              r_letters, n_letters;
    logic [1:0]        r_alive,   n_alive;
    logic [BYTE_W-1:0] r_first,   n_first;
    logic [POS_W-1:0]  r_start,   n_start;
    logic [POS_W-1:0]  r_pos,     n_pos;
    logic              r_halted,  n_halted;

    logic              is_sep;
    logic              is_nl;
    logic              is_quote;
    logic              is_mark;
    logic [LEN_W-1:0]  a_len;
    logic              a_digits;
    logic              a_letters;
    logic [1:0]        a_alive;
    logic [BYTE_W-1:0] a_first;
    logic [POS_W-1:0]  a_start;
    logic [LEN_W-1:0]  w_len;
    logic              w_digits;
    logic              w_letters;
    logic [1:0]        w_alive;
    logic [BYTE_W-1:0] w_first;
    logic [POS_W-1:0]  w_start;
    t_kind             w_kind;
    logic              w_err;
    logic              v_w, v_m, v_e;
    logic [POS_W-1:0]  pos_inc;
    logic              active;

    assign active   = i_valid && !r_halted;
    assign is_nl    = (i_byte == CH_NL);
    assign is_sep   = (i_byte == CH_SPACE) || is_nl;
    assign is_quote = (i_byte == CH_SQUOTE) || (i_byte == CH_DQUOTE);
    assign is_mark  = is_sep || is_quote;
    assign pos_inc  = r_pos + POS_W'(1);

    always_comb begin
        logic fresh;
        fresh     = (r_len == '0);
        a_start   = fresh ? r_pos  : r_start;
        a_first   = fresh ? i_byte : r_first;
        a_digits  = (fresh || r_digits)  && is_digit(i_byte);
        a_letters = (fresh || r_letters) && is_letter(i_byte);
        a_alive   = fresh ? 2'b11 : r_alive;
        if (r_len < LEN_W'(3)) begin
            if (i_byte != kw_char(1'b0, r_len[1:0])) a_alive[0] = 1'b0;
            if (i_byte != kw_char(1'b1, r_len[1:0])) a_alive[1] = 1'b0;
        end else begin
            a_alive = 2'b00;
        end
        a_len = (r_len < LEN_W'(MAX_WORD_LEN)) ? r_len + LEN_W'(1) : r_len;
    end

    always_comb begin
        if (is_mark) begin
            w_len     = r_len;
            w_digits  = r_digits;
            w_letters = r_letters;
            w_alive   = r_alive;
            w_first   = r_first;
            w_start   = r_start;
        end else begin
            w_len     = a_len;
            w_digits  = a_digits;
            w_letters = a_letters;
            w_alive   = a_alive;
            w_first   = a_first;
            w_start   = a_start;
        end
        w_kind = classify(w_len, w_digits, w_letters, w_alive, w_first);
    end

    always_comb begin
        v_w   = is_mark ? (r_len != '0) : i_last;
        w_err = v_w && (w_kind == KIND_ERROR);
        v_m   = (is_nl || is_quote) && !w_err;
        v_e   = i_last && !is_nl && !w_err;
    end

    always_comb begin
        o_push.valid = active ? {v_e, v_m, v_w} : 3'b000;

        o_push.tok[0].kind   = w_kind;
        o_push.tok[0].start  = START_W'(w_start);
        o_push.tok[0].length = w_len;
        o_push.tok[0].symbol = w_first;
        o_push.tok[0].last   = !v_m && !v_e;

        o_push.tok[1].kind   = is_nl ? KIND_ENDSTATEMENT : KIND_PUNCTUATOR;
        o_push.tok[1].start  = START_W'(r_pos);
        o_push.tok[1].length = is_nl ? LEN_W'(0) : LEN_W'(1);
        o_push.tok[1].symbol = i_byte;
        o_push.tok[1].last   = !v_e;

        o_push.tok[2].kind   = KIND_ENDSTATEMENT;
        o_push.tok[2].start  = START_W'(pos_inc);
        o_push.tok[2].length = LEN_W'(0);
        o_push.tok[2].symbol = CH_NL;
        o_push.tok[2].last   = 1'b1;
    end

    always_comb begin
        n_len     = r_len;
        n_digits  = r_digits;
        n_letters = r_letters;
        n_alive   = r_alive;
        n_first   = r_first;
        n_start   = r_start;
        n_pos     = r_pos;
        n_halted  = r_halted;
        if (active) begin
            n_pos    = pos_inc;
            n_halted = w_err;
            if (is_mark || i_last) begin
                n_len     = '0;
                n_digits  = 1'b1;
                n_letters = 1'b1;
                n_alive   = 2'b11;
                n_first   = '0;
                n_start   = '0;
            end else begin
                n_len     = a_len;
                n_digits  = a_digits;
                n_letters = a_letters;
                n_alive   = a_alive;
                n_first   = a_first;
                n_start   = a_start;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_digits  <= 1'b1;
            r_letters <= 1'b1;
            r_alive   <= 2'b11;
            r_first   <= '0;
            r_start   <= '0;
            r_pos     <= '0;
            r_halted  <= 1'b0;
        end else begin
            r_len     <= n_len;
            r_digits  <= n_digits;
            r_letters <= n_letters;
            r_alive   <= n_alive;
            r_first   <= n_first;
            r_start   <= n_start;
            r_pos     <= n_pos;
            r_halted  <= n_halted;
        end
    end

endmodule

### rtl/wtc_token_fifo.sv
// Token queue: takes up to three tokens a cycle, hands out one a cycle while the reader is ready.
// Depends on wtc_pkg.
module wtc_token_fifo
    import wtc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    output logic   o_room,
    output logic   o_valid,
    input  logic   i_ready,
    output t_token o_token
);

    t_token             r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [FIFO_AW:0]   r_count,  n_count;
    logic [FIFO_AW-1:0] off1, off2;
    logic [1:0]         npush;
    logic               pop;

    assign o_room  = r_count <= (FIFO_AW+1)'(FIFO_DEPTH - 3);
    assign o_valid = r_count != '0;
    assign o_token = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;

    always_comb begin
        off1     = FIFO_AW'(i_push.valid[0]);
        off2     = FIFO_AW'(i_push.valid[0]) + FIFO_AW'(i_push.valid[1]);
        npush    = 2'(i_push.valid[0]) + 2'(i_push.valid[1]) + 2'(i_push.valid[2]);
        n_wr_ptr = r_wr_ptr + FIFO_AW'(npush);
        n_rd_ptr = r_rd_ptr + FIFO_AW'(pop);
        n_count  = r_count + (FIFO_AW+1)'(npush) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid[0]) r_mem[r_wr_ptr]        <= i_push.tok[0];
        if (i_push.valid[1]) r_mem[r_wr_ptr + off1] <= i_push.tok[1];
        if (i_push.valid[2]) r_mem[r_wr_ptr + off2] <= i_push.tok[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

### rtl/word_token_classifier.sv
// Word token classifier top level: input byte register, lexer, token queue.
// An accepted byte is held in the input register, then its tokens are written into the token queue.
// Throughput: one byte per cycle while the 8-entry token queue has room for 3.
// Synchronous active-low reset clears word state, position, halt flag and queue.
// Depends on wtc_pkg, wtc_lexer, wtc_token_fifo.
module word_token_classifier
    import wtc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,  // [7:0] text_byte
    input  logic               s_axis_tlast,  // end_of_text
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,  // [2:0] token_kind, [18:3] token_start,
                                              // [26:19] token_length, [34:27] first_symbol
    output logic               m_axis_tlast   // last_of_run
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    logic              room;
    logic              advance;
    t_push             push;
    t_token            token;

    assign advance       = r_in_valid && room;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    wtc_lexer u_lexer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (advance),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_push  (push)
    );

    wtc_token_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_token (token)
    );

    assign m_axis_tdata = {(TDATA_W - 35)'(0), token.symbol, token.length,
                           token.start, token.kind};
    assign m_axis_tlast = token.last;

endmodule

### verif/tb_top.sv
// Testbench for word_token_classifier: streams source text and checks every token.
// Predicts tokens with its own word-state tracker; sender gaps and receiver stalls vary.
// Depends on wtc_pkg and the word_token_classifier RTL.
`timescale 1ns / 1ps

module tb_top;
    import wtc_pkg::*;

    typedef struct {
        t_kind       kind;
        logic [15:0] start;
        logic [7:0]  len;
        logic [7:0]  sym;
        logic        last;
    } t_lex_token;

    localparam logic [23:0] KW_INT       = "int";
    localparam logic [23:0] KW_STR       = "str";
    localparam int          RANDOM_BYTES = 50;
    localparam int          FINAL_WAIT   = 8;
    localparam int          MAX_REPORTS  = 40;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = 8'h00;
    logic               s_axis_tlast = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic               m_axis_tlast;

    word_token_classifier uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // word tracker state
    logic [7:0]  word_len   = 8'd0;
    logic        all_digits = 1'b1;
    logic        all_alpha  = 1'b1;
    logic [1:0]  kw_alive   = 2'b11;
    logic [7:0]  word_sym   = 8'd0;
    logic [15:0] word_pos   = 16'd0;
    logic [15:0] text_pos   = 16'd0;
    logic        halted     = 1'b0;

    t_lex_token  pending_tokens[$];
    t_lex_token  step_tokens[$];

    byte unsigned text_buf[$];
    int          burst_left  = 0;
    bit          gaps_on     = 1'b1;
    int          bytes_sent  = 0;

    int          rx_mode     = 0;
    int          rx_run      = 0;
    logic        rx_hold     = 1'b1;

    int          errors      = 0;
    int          tokens_seen = 0;
    int          kind_count[8] = '{default: 0};

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] kw_ch(input logic [23:0] kw, input int idx);
        return kw[23 - 8*idx -: 8];
    endfunction

    function automatic void put_char(input logic [7:0] b);
        text_buf.insert(text_buf.size(), b);
    endfunction

    function automatic void emit_token(input t_kind k, input logic [15:0] st,
                                       input logic [7:0] ln, input logic [7:0] sy);
        t_lex_token t;
        t.kind  = k;
        t.start = st;
        t.len   = ln;
        t.sym   = sy;
        t.last  = 1'b0;
        step_tokens.insert(step_tokens.size(), t);
    endfunction

    function automatic void flush_word();
        t_kind k;
        if (word_len == 8'd0) return;
        if (word_len == 8'd3 && kw_alive != 2'b00) k = KIND_DATATYPE;
        else if (all_digits) k = KIND_NUMBER;
        else if (word_len == 8'd1 && word_sym == CH_EQ) k = KIND_ASSIGNMENT;
        else if (word_len == 8'd1 && (word_sym == CH_STAR || word_sym == CH_PLUS ||
                                      word_sym == CH_MINUS || word_sym == CH_SLASH))
            k = KIND_OPERATOR;
        else if (all_alpha) k = KIND_STRING;
        else k = KIND_ERROR;
        emit_token(k, word_pos, word_len, word_sym);
        if (k == KIND_ERROR) halted = 1'b1;
        word_len   = 8'd0;
        all_digits = 1'b1;
        all_alpha  = 1'b1;
        kw_alive   = 2'b11;
        word_sym   = 8'd0;
        word_pos   = 16'd0;
    endfunction

    function automatic void append_char(input logic [7:0] c, input logic [15:0] p);
        if (word_len == 8'd0) begin
            word_pos   = p;
            word_sym   = c;
            all_digits = 1'b1;
            all_alpha  = 1'b1;
            kw_alive   = 2'b11;
        end
        if (!(c >= "0" && c <= "9")) all_digits = 1'b0;
        if (!((c >= "A" && c <= "Z") || (c >= "a" && c <= "z"))) all_alpha = 1'b0;
        if (word_len < 8'd3) begin
            if (c != kw_ch(KW_INT, word_len)) kw_alive[0] = 1'b0;
            if (c != kw_ch(KW_STR, word_len)) kw_alive[1] = 1'b0;
        end else begin
            kw_alive = 2'b00;
        end
        if (word_len < MAX_WORD_LEN) word_len++;
    endfunction

    function automatic void lex_step(input logic [7:0] c, input logic last);
        logic [15:0] p;
        if (halted) return;
        p = text_pos;
        text_pos = text_pos + 16'd1;
        if (c == CH_SPACE || c == CH_NL) begin
            flush_word();
            if (!halted && c == CH_NL) emit_token(KIND_ENDSTATEMENT, p, 8'd0, CH_NL);
        end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
            flush_word();
            if (!halted) emit_token(KIND_PUNCTUATOR, p, 8'd1, c);
        end else begin
            append_char(c, p);
        end
        if (last && !halted && c != CH_NL) begin
            flush_word();
            if (!halted) emit_token(KIND_ENDSTATEMENT, text_pos, 8'd0, CH_NL);
        end
        if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i]) pending_tokens.insert(pending_tokens.size(), step_tokens[i]);
        step_tokens.delete();
    endfunction

    // send one byte; tvalid stays high for a following call in the same step
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (gaps_on && burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0) burst_left--;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        lex_step(b, last);
        bytes_sent++;
    endtask

    task automatic send_buf(input bit end_text);
        int n;
        n = text_buf.size();
        for (int i = 0; i < n; i++) send_byte(text_buf[i], end_text && i == n - 1);
        text_buf.delete();
    endtask

    task automatic send_str(input string s, input bit end_text);
        for (int i = 0; i < s.len(); i++) put_char(s[i]);
        send_buf(end_text);
    endtask

    function automatic void push_letter();
        if ($urandom_range(0, 1)) put_char(8'("A" + $urandom_range(0, 25)));
        else put_char(8'("a" + $urandom_range(0, 25)));
    endfunction

    function automatic void push_digits(input int n);
        repeat (n) put_char(8'("0" + $urandom_range(0, 9)));
    endfunction

    function automatic void push_random_word();
        int          sel;
        int          n;
        logic [23:0] kw;
        logic [7:0]  ops[4];
        sel = $urandom_range(0, 9);
        kw  = $urandom_range(0, 1) ? KW_STR : KW_INT;
        ops = '{CH_STAR, CH_PLUS, CH_MINUS, CH_SLASH};
        case (sel)
            0, 1: begin
                for (int i = 0; i < 3; i++) put_char(kw_ch(kw, i));
            end
            2, 3: push_digits($urandom_range(1, 5));
            4: put_char(CH_EQ);
            5: put_char(ops[$urandom_range(0, 3)]);
            6: begin
                // near-miss of a datatype keyword
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) begin
                    if (i < 3) put_char(kw_ch(kw, i));
                    else push_letter();
                end
                if (n == 3) text_buf[text_buf.size() - 3] = kw_ch(kw, 0) - 8'd32;
            end
            default: repeat ($urandom_range(1, 8)) push_letter();
        endcase
    endfunction

    function automatic void push_separator();
        case ($urandom_range(0, 7))
            0: put_char(CH_SQUOTE);
            1: put_char(CH_DQUOTE);
            2: begin
                put_char(CH_SPACE);
                put_char(CH_SPACE);
            end
            default: put_char(CH_SPACE);
        endcase
    endfunction

    task automatic test_directed();
        gaps_on = 1'b0;
        rx_mode = 0;
        send_str("int a = 90\n", 1'b0);
        gaps_on = 1'b1;
        send_str("str '* + - /\" zZ", 1'b1);
    endtask

    task automatic test_random_text();
        int target;
        int nw;
        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            rx_mode = $urandom_range(0, 2);
            if ($urandom_range(0, 4) == 0) push_separator();
            nw = $urandom_range(1, 6);
            for (int i = 0; i < nw; i++) begin
                push_random_word();
                if (i < nw - 1) push_separator();
            end
            case ($urandom_range(0, 5))
                0: send_buf(1'b1);
                1: begin
                    put_char(CH_NL);
                    send_buf(1'b1);
                end
                2: begin
                    push_separator();
                    send_buf(1'b1);
                end
                default: begin
                    put_char(CH_NL);
                    send_buf(1'b0);
                end
            endcase
        end
    endtask

    task automatic test_long_words();
        gaps_on = 1'b1;
        rx_mode = 2;
        for (int i = 0; i < 3; i++) put_char(kw_ch(KW_INT, i));
        repeat (MAX_WORD_LEN - 1) push_letter();
        put_char(CH_DQUOTE);
        push_digits(3);
        send_buf(1'b1);
    endtask

    task automatic test_error_halt();
        gaps_on = 1'b1;
        rx_mode = 2;
        send_str("v = 3 'k", 1'b0);
        put_char("a");
        put_char(8'hFF);
        put_char("b");
        put_char(CH_NL);
        send_buf(1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        repeat (10) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    function automatic void check_field(input string name, input longint unsigned expv,
                                        input longint unsigned actv);
        if (expv != actv) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, expv, actv);
        end
    endfunction

    always @(posedge i_clk) begin : token_sink
        t_lex_token e;
        if (m_axis_tvalid && m_axis_tready) begin
            tokens_seen++;
            kind_count[m_axis_tdata[2:0]]++;
            if (pending_tokens.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected token: expected none, got tdata %h last %b",
                             $time, m_axis_tdata, m_axis_tlast);
            end else begin
                e = pending_tokens.pop_front();
                check_field("token_kind", e.kind, m_axis_tdata[2:0]);
                check_field("token_start", e.start, m_axis_tdata[18:3]);
                check_field("token_length", e.len, m_axis_tdata[26:19]);
                check_field("first_symbol", e.sym, m_axis_tdata[34:27]);
                check_field("last_of_run", e.last, m_axis_tlast);
                check_field("tdata padding", 0, m_axis_tdata[TDATA_W-1:35]);
            end
        end
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: begin
                // alternate ready and stall runs
                if (rx_run == 0) begin
                    rx_run  = $urandom_range(1, 16);
                    rx_hold = ~rx_hold;
                end
                rx_run--;
                m_axis_tready <= rx_hold;
            end
        endcase
    end

    initial begin
        #8_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_text();
        test_long_words();
        test_error_halt();
        s_axis_tvalid <= 1'b0;
        while (pending_tokens.size() != 0) @(posedge i_clk);
        repeat (FINAL_WAIT) @(posedge i_clk);
        $display("Streamed %0d text bytes and checked %0d tokens, with a saturating long word",
                 bytes_sent, tokens_seen);
        $display("and a halting error; tokens per kind 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
                 kind_count[0], kind_count[1], kind_count[2], kind_count[3],
                 kind_count[4], kind_count[5], kind_count[6], kind_count[7]);
        if (errors == 0 && pending_tokens.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### files.f
rtl/wtc_pkg.sv
rtl/wtc_lexer.sv
rtl/wtc_token_fifo.sv
rtl/word_token_classifier.sv
verif/tb_top.sv
